// File: sv/wpcov_pkg.sv
`timescale 1ns / 1ps
package wpcov_pkg;

  localparam int MAX_VARS   = 64;
  localparam int MAX_WINDOW = 8;
  localparam int MAX_ROWS   = 65536;

  localparam int VAR_W   = $clog2(MAX_VARS);
  localparam int OFF_W   = $clog2(MAX_WINDOW);
  localparam int PAIR_W  = VAR_W + OFF_W;
  localparam int PAIRS   = MAX_VARS * MAX_WINDOW;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 40;
  localparam int PROD_W  = 64;
  localparam int SMP_W   = 24;
  localparam int DIV_W   = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    logic signed [SUM_W-1:0]  s1;
    logic signed [SUM_W-1:0]  s2;
    logic signed [PROD_W-1:0] c;
  } acc_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

// File: sv/windowed_pairwise_covariance.sv
`timescale 1ns / 1ps
// Channel  Dir  Signals                      Content (low bit first)
// s_axis   in   tvalid tready tdata tuser    tdata: sample_value, var_index, offset_index
//                                            tuser: action, is_nan
// m_axis   out  tvalid tready tdata          tdata: covariance, pair_count
// cfg      in   cfg_we_i cfg_index_i         0 num_vars, 1 window
// A row-ending sample then walks the row: each variable is read, and a present
// one is accumulated with each present partner in its window; missing ones are skipped.
// A read with a nonzero pair count runs three 64-step divisions in one divider.
// Reset and clear run a zeroing pass over all 512 accumulator entries
// while tready is low. A result waits in the output register under stall.
module windowed_pairwise_covariance
  import wpcov_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // sample_value, var_index, offset_index
  input  logic [2:0]   s_axis_tuser,  // action, is_nan
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata   // covariance, pair_count
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RI, S_RIW, S_RJ, S_RJW, S_WR,
    S_RD, S_RDW, S_D1, S_D2, S_D3, S_PM, S_FIN, S_OUT
  } state_e;

  state_e                   state_q;
  logic [6:0]               nv_cfg_q;
  logic [3:0]               win_cfg_q;
  logic [6:0]               nv_eff, nv_run_q;
  logic [3:0]               win_eff, win_run_q;
  logic [VAR_W-1:0]         col_q, i_q, j_q;
  logic [3:0]               k_q;
  logic [CNT_W-1:0]         rows_q;
  logic [PAIR_W-1:0]        clr_q, rd_addr_q;
  logic signed [SMP_W-1:0]  vi_q, vj_q;
  logic signed [47:0]       prod_q;
  acc_t                     acc_q;
  logic signed [63:0]       t_q, cov_q, pm_q, pm_adj;
  logic signed [31:0]       m1_q;
  logic signed [31:0]       m2_q;
  logic                     m_valid_q;
  logic [87:0]              m_data_q;
  div_req_t                 div_req_q;
  logic                     div_done;
  logic signed [63:0]       div_quot;

  logic [SMP_W:0]           row_mem [MAX_VARS];
  logic [SMP_W:0]           row_rd_q;
  logic [VAR_W-1:0]         row_raddr;
  logic                     row_we;
  acc_t                     acc_mem [PAIRS];
  acc_t                     acc_rd_q, acc_wdata;
  logic [PAIR_W-1:0]        acc_raddr, acc_waddr, pair_addr;
  logic                     acc_we;

  action_e                  act;
  logic signed [SMP_W-1:0]  in_val;
  logic                     in_miss, accept, last_col, j_miss;
  logic [VAR_W-1:0]         j_next;

  assign act     = action_e'(s_axis_tuser[1:0]);
  assign in_val  = $signed(s_axis_tdata[SMP_W-1:0]);
  assign in_miss = s_axis_tuser[2] ||
                   (in_val >= 24'sd266236 && in_val <= 24'sd266244);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign nv_eff  = (nv_cfg_q == '0) ? 7'd1 :
                   (nv_cfg_q > 7'(MAX_VARS)) ? 7'(MAX_VARS) : nv_cfg_q;
  assign win_eff = (win_cfg_q == '0) ? 4'd1 :
                   (win_cfg_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : win_cfg_q;
  assign last_col  = ({1'b0, col_q} + 7'd1) >= nv_eff;
  assign j_next    = (({1'b0, j_q} + 7'd1) == nv_run_q) ? '0 : j_q + 1'b1;
  assign j_miss    = row_rd_q[SMP_W];
  assign pair_addr = {i_q, 3'(k_q - 4'd1)};
  assign pm_adj    = pm_q + (pm_q[63] ? 64'sd4095 : 64'sd0);

  assign row_we    = accept && act == ACT_SAMPLE && rows_q < CNT_W'(MAX_ROWS);
  assign row_raddr = (state_q == S_RJ) ? j_q : i_q;
  assign acc_raddr = (state_q == S_RD) ? rd_addr_q : pair_addr;
  assign acc_we    = (state_q == S_CLR) || (state_q == S_WR);
  assign acc_waddr = (state_q == S_CLR) ? clr_q : pair_addr;

  always_comb begin
    acc_wdata = '0;
    if (state_q == S_WR) begin
      acc_wdata.cnt = acc_q.cnt + 1'b1;
      acc_wdata.s1  = acc_q.s1 + SUM_W'(vi_q);
      acc_wdata.s2  = acc_q.s2 + SUM_W'(vj_q);
      acc_wdata.c   = acc_q.c + PROD_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[col_q] <= {in_miss, in_val};
    row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_q <= acc_mem[acc_raddr];
  end

  wpcov_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      nv_cfg_q  <= 7'd64;
      win_cfg_q <= 4'd8;
      col_q     <= '0;
      rows_q    <= '0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      div_req_q <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i) win_cfg_q <= cfg_data_i[3:0];
        else             nv_cfg_q  <= cfg_data_i;
      end
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_CLEAR: begin
                col_q   <= '0;
                rows_q  <= '0;
                clr_q   <= '0;
                state_q <= S_CLR;
              end
              ACT_SAMPLE: begin
                if (row_we) begin
                  if (last_col) begin
                    col_q     <= '0;
                    rows_q    <= rows_q + 1'b1;
                    i_q       <= '0;
                    nv_run_q  <= nv_eff;
                    win_run_q <= win_eff;
                    state_q   <= S_RI;
                  end else begin
                    col_q <= col_q + 1'b1;
                  end
                end
              end
              ACT_READ: begin
                rd_addr_q <= {s_axis_tdata[29:24], s_axis_tdata[32:30]};
                state_q   <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RI: state_q <= S_RIW;
        S_RIW: begin
          if (row_rd_q[SMP_W]) begin
            if (({1'b0, i_q} + 7'd1) == nv_run_q) state_q <= S_IDLE;
            else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RI;
            end
          end else begin
            vi_q    <= row_rd_q[SMP_W-1:0];
            k_q     <= 4'd1;
            j_q     <= (({1'b0, i_q} + 7'd1) == nv_run_q) ? '0 : i_q + 1'b1;
            state_q <= S_RJ;
          end
        end
        S_RJ: state_q <= S_RJW;
        S_RJW, S_WR: begin
          if (state_q == S_RJW && !j_miss) begin
            vj_q    <= row_rd_q[SMP_W-1:0];
            acc_q   <= acc_rd_q;
            prod_q  <= vi_q * $signed(row_rd_q[SMP_W-1:0]);
            state_q <= S_WR;
          end else if (k_q == win_run_q) begin
            if (({1'b0, i_q} + 7'd1) == nv_run_q) state_q <= S_IDLE;
            else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RI;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            j_q     <= j_next;
            state_q <= S_RJ;
          end
        end
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          acc_q <= acc_rd_q;
          if (acc_rd_q.cnt == '0) begin
            cov_q   <= '0;
            state_q <= S_OUT;
          end else begin
            div_req_q <= '{start: 1'b1, dividend: acc_rd_q.c, divisor: acc_rd_q.cnt};
            state_q   <= S_D1;
          end
        end
        S_D1: begin
          if (div_done) begin
            t_q       <= div_quot;
            div_req_q <= '{start: 1'b1, dividend: {{18{acc_q.s1[SUM_W-1]}}, acc_q.s1, 6'd0},
                           divisor: acc_q.cnt};
            state_q   <= S_D2;
          end
        end
        S_D2: begin
          if (div_done) begin
            m1_q      <= div_quot[31:0];
            div_req_q <= '{start: 1'b1, dividend: {{18{acc_q.s2[SUM_W-1]}}, acc_q.s2, 6'd0},
                           divisor: acc_q.cnt};
            state_q   <= S_D3;
          end
        end
        S_D3: begin
          if (div_done) begin
            m2_q    <= div_quot[31:0];
            state_q <= S_PM;
          end
        end
        S_PM: begin
          pm_q    <= m1_q * m2_q;
          state_q <= S_FIN;
        end
        S_FIN: begin
          cov_q   <= t_q - (pm_adj >>> 12);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {7'd0, acc_q.cnt, cov_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: sv/wpcov_div.sv
`timescale 1ns / 1ps
module wpcov_div
  import wpcov_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] quot_o
);

  logic                     busy_q, done_q, neg_q;
  logic [$clog2(DIV_W)-1:0] cnt_q;
  logic [CNT_W-1:0]         rem_q, div_q;
  logic [DIV_W-1:0]         quot_q;
  logic [CNT_W:0]           sh;
  logic [CNT_W:0]           diff;
  logic                     qbit;
  logic [DIV_W-1:0]         mag;

  always_comb begin
    sh   = {rem_q, quot_q[DIV_W-1]};
    diff = sh - {1'b0, div_q};
    qbit = (sh >= {1'b0, div_q});
    mag  = req_i.dividend[DIV_W-1] ? DIV_W'(-req_i.dividend) : DIV_W'(req_i.dividend);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= mag;
      div_q  <= req_i.divisor;
      neg_q  <= req_i.dividend[DIV_W-1];
    end else if (busy_q) begin
      rem_q  <= qbit ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
      quot_q <= {quot_q[DIV_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? DIV_W'(-$signed(quot_q)) : $signed(quot_q);

endmodule

// File: test/windowed_pairwise_covariance_tb.sv
`timescale 1ns / 1ps
module windowed_pairwise_covariance_tb;
  import wpcov_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int SETTLE = 2700;
  localparam logic signed [23:0] SIXTY_FIVE = 24'sd266240;

  typedef struct {
    longint cov;
    int     cnt;
  } cov_result_t;

  typedef struct {
    action_e     act;
    int          val;
    bit          nan;
    int          var_i;
    int          off_i;
    bit          typed;
    longint      cov;
    int          cnt;
  } stim_row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [87:0] m_axis_tdata;

  windowed_pairwise_covariance uut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // shadow state
  int          vars_reg, win_reg;
  int          row_vals[MAX_VARS];
  bit          row_gone[MAX_VARS];
  int          col_pos, row_total;
  int          cnt_acc[PAIRS];
  longint      s1_acc[PAIRS], s2_acc[PAIRS], prod_acc[PAIRS];
  cov_result_t cov_pending[$];
  int          errors = 0;
  int          cycles = 0;
  int          rx_hold = 0;
  bit          quiet = 0;
  bit          typed_next = 0;
  cov_result_t typed_res;

  function automatic void wipe_accumulators();
    for (int i = 0; i < MAX_VARS; i++) begin
      row_vals[i] = 0;
      row_gone[i] = 0;
    end
    for (int a = 0; a < PAIRS; a++) begin
      cnt_acc[a] = 0;
      s1_acc[a] = 0;
      s2_acc[a] = 0;
      prod_acc[a] = 0;
    end
    col_pos = 0;
    row_total = 0;
  endfunction

  function automatic void fold_row(int nv);
    int nw, j, a;
    nw = win_reg < 1 ? 1 : (win_reg > MAX_WINDOW ? MAX_WINDOW : win_reg);
    for (int i = 0; i < nv; i++) begin
      if (!row_gone[i]) begin
        for (int k = 1; k <= nw; k++) begin
          j = (i + k) % nv;
          a = i * MAX_WINDOW + k - 1;
          if (!row_gone[j]) begin
            cnt_acc[a]++;
            s1_acc[a] += row_vals[i];
            s2_acc[a] += row_vals[j];
            prod_acc[a] += longint'(row_vals[i]) * longint'(row_vals[j]);
          end
        end
      end
    end
  endfunction

  function automatic cov_result_t pair_covariance(int var_i, int off_i);
    cov_result_t r;
    int a;
    longint n, m1, m2;
    a = var_i * MAX_WINDOW + off_i;
    r.cnt = cnt_acc[a];
    r.cov = 0;
    if (r.cnt > 0) begin
      n = r.cnt;
      m1 = (s1_acc[a] * 64) / n;
      m2 = (s2_acc[a] * 64) / n;
      r.cov = prod_acc[a] / n - (m1 * m2) / 4096;
    end
    return r;
  endfunction

  function automatic void take_sample(logic signed [23:0] v, bit nan);
    int nv, c, d;
    nv = vars_reg < 1 ? 1 : (vars_reg > MAX_VARS ? MAX_VARS : vars_reg);
    d = int'(v) - int'(SIXTY_FIVE);
    if (row_total >= MAX_ROWS) return;
    c = col_pos >= MAX_VARS ? MAX_VARS - 1 : col_pos;
    row_vals[c] = v;
    row_gone[c] = nan || (d >= -4 && d <= 4);
    if (c + 1 >= nv) begin
      fold_row(nv);
      col_pos = 0;
      row_total++;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  always @(posedge clk_i) begin
    cov_result_t r, e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && cfg_we_i) begin
      if (cfg_index_i) win_reg = cfg_data_i & 7'h0F;
      else vars_reg = cfg_data_i;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      case (action_e'(s_axis_tuser[1:0]))
        ACT_CLEAR: wipe_accumulators();
        ACT_SAMPLE: take_sample(s_axis_tdata[23:0], s_axis_tuser[2]);
        ACT_READ: begin
          r = pair_covariance(s_axis_tdata[29:24], s_axis_tdata[32:30]);
          cov_pending.push_back(typed_next ? typed_res : r);
        end
        default: ;
      endcase
      typed_next = 0;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cov_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cov=%0d cnt=%0d", $time,
                 $signed(m_axis_tdata[63:0]), m_axis_tdata[80:64]);
      end else begin
        e = cov_pending.pop_front();
        if ($signed(m_axis_tdata[63:0]) != e.cov) begin
          errors++;
          $display("%0t: covariance expected %0d actual %0d", $time, e.cov,
                   $signed(m_axis_tdata[63:0]));
        end
        if (m_axis_tdata[80:64] != e.cnt[16:0]) begin
          errors++;
          $display("%0t: pair_count expected %0d actual %0d", $time, e.cnt,
                   m_axis_tdata[80:64]);
        end
      end
    end
  end

  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        w = rx_hold;
        rx_hold = 0;
      end else begin
        w = quiet ? 0 : $urandom_range(0, 12);
      end
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  task automatic send_req(action_e act, int val, bit nan, int var_i, int off_i, bit nogap);
    int w;
    w = (nogap || quiet) ? 0 : $urandom_range(0, 12);
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tdata <= {7'd0, off_i[2:0], var_i[5:0], val[23:0]};
    s_axis_tuser <= {nan, act};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    while (cov_pending.size() > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_config(int nv, int win);
    cfg_we_i <= 1;
    cfg_index_i <= 0;
    cfg_data_i <= nv[6:0];
    @(negedge clk_i);
    cfg_index_i <= 1;
    cfg_data_i <= win[6:0];
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 8388607 : -8388608;
      1: return 266240 + int'($urandom_range(0, 12)) - 6;
      2: return int'($urandom_range(0, 8191)) - 4096;
      default: return int'({{8{1'b0}}, $urandom} << 8) >>> 8;
    endcase
  endfunction

  task automatic random_item(int nv);
    int r, v;
    r = $urandom_range(0, 99);
    v = pick_value();
    if (r < 70) begin
      send_req(ACT_SAMPLE, v, $urandom_range(0, 9) == 0, $urandom_range(0, 63),
               $urandom_range(0, 7), 0);
    end else if (r < 94) begin
      send_req(ACT_READ, v, $urandom_range(0, 1),
               $urandom_range(0, 3) != 0 ? $urandom_range(0, nv - 1) : $urandom_range(0, 63),
               $urandom_range(0, 7), 0);
    end else if (r < 97) begin
      send_req(ACT_NONE, v, $urandom_range(0, 1), $urandom_range(0, 63),
               $urandom_range(0, 7), 0);
    end else begin
      send_req(ACT_CLEAR, v, $urandom_range(0, 1), $urandom_range(0, 63),
               $urandom_range(0, 7), 0);
    end
  endtask

  stim_row_t plan[] = '{
    '{ACT_READ,   0,        0, 0, 0, 1, 0, 0},
    '{ACT_READ,   -1,       1, 63, 7, 1, 0, 0},
    '{ACT_NONE,   123,      1, 5, 5, 0, 0, 0},
    '{ACT_SAMPLE, 8388607,  0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, -8388608, 0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 266240,   0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 266244,   0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 266236,   0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 266245,   0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 266235,   0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 0,        1, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 4096,     0, 63, 7, 0, 0, 0},
    '{ACT_SAMPLE, -4096,    0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 8388607,  0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, -1,       0, 0, 0, 0, 0, 0},
    '{ACT_READ,   0,        0, 0, 0, 0, 0, 0},
    '{ACT_READ,   0,        0, 1, 1, 0, 0, 0},
    '{ACT_READ,   0,        0, 2, 2, 0, 0, 0},
    '{ACT_READ,   0,        0, 3, 0, 0, 0, 0},
    '{ACT_READ,   0,        0, 0, 7, 1, 0, 0},
    '{ACT_CLEAR,  0,        0, 0, 0, 0, 0, 0},
    '{ACT_READ,   0,        0, 0, 0, 1, 0, 0},
    '{ACT_SAMPLE, 8388607,  0, 0, 0, 0, 0, 0},
    '{ACT_READ,   0,        0, 0, 0, 0, 0, 0}
  };

  int phase_nv[8] = '{1, 64, 2, 7, 0, 127, 13, 3};
  int phase_win[8] = '{1, 8, 8, 2, 0, 15, 5, 1};

  initial begin
    int nv;
    vars_reg = MAX_VARS;
    win_reg = MAX_WINDOW;
    wipe_accumulators();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    set_config(4, 3);
    foreach (plan[i]) begin
      typed_next = plan[i].typed;
      typed_res.cov = plan[i].cov;
      typed_res.cnt = plan[i].cnt;
      send_req(plan[i].act, plan[i].val, plan[i].nan, plan[i].var_i, plan[i].off_i, 0);
    end
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      set_config(phase_nv[p], phase_win[p]);
      nv = phase_nv[p] < 1 ? 1 : (phase_nv[p] > MAX_VARS ? MAX_VARS : phase_nv[p]);
      quiet = (p == 3);
      if (p == 2) rx_hold = 400;
      for (int n = 0; n < 55; n++) begin
        if (p == 2 && n < 20)
          send_req(ACT_READ, 0, 0, $urandom_range(0, 1), $urandom_range(0, 7), 1);
        else
          random_item(nv);
      end
      quiet = 0;
      wait_drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
